### hw/rtl/aapb_pkg.sv
// Package for the anti-aliased pixel blend core.
// Holds the shared types, register indexes and the reciprocal table.
// No dependencies.
package aapb_pkg;

    localparam int NUM_LANES = 8;
    localparam int RECIP_FRAC = 16;

    localparam logic [2:0] CFG_RED_SHIFT    = 3'd0;
    localparam logic [2:0] CFG_GREEN_SHIFT  = 3'd1;
    localparam logic [2:0] CFG_BLUE_SHIFT   = 3'd2;
    localparam logic [2:0] CFG_FRAME_WIDTH  = 3'd3;
    localparam logic [2:0] CFG_FRAME_HEIGHT = 3'd4;
    localparam logic [2:0] CFG_BACKGROUND   = 3'd5;

    localparam logic [8:0] BRIGHT_FULL = 9'd256;

    typedef struct packed {
        logic [4:0] red;
        logic [4:0] green;
        logic [4:0] blue;
    } t_shifts;

    typedef struct packed {
        logic       diff;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
    } t_lane_res;

    typedef struct packed {
        logic [3:0]  cnt;
        logic [10:0] sum_r;
        logic [10:0] sum_g;
        logic [10:0] sum_b;
    } t_sums;

    // Rounded-up 2^16 / n, exact for floor division of sums below 2048.
    function automatic logic [16:0] f_recip(input logic [3:0] n);
        logic [16:0] m;
        unique case (n)
            4'd1:    m = 17'd65536;
            4'd2:    m = 17'd32768;
            4'd3:    m = 17'd21846;
            4'd4:    m = 17'd16384;
            4'd5:    m = 17'd13108;
            4'd6:    m = 17'd10923;
            4'd7:    m = 17'd9363;
            4'd8:    m = 17'd8192;
            default: m = 17'd0;
        endcase
        return m;
    endfunction

endpackage

### hw/rtl/aapb_lane.sv
// One neighbour lane of the anti-aliased pixel blend core.
// Decodes a raw framebuffer word and flags whether it differs from the drawing colour.
// Depends on aapb_pkg.
module aapb_lane (
    input  logic [31:0]         i_word,
    input  logic                i_en,
    input  logic [23:0]         i_draw_rgb,
    input  aapb_pkg::t_shifts   i_shifts,
    output aapb_pkg::t_lane_res o_res
);
    import aapb_pkg::*;

    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic        diff;

    assign red   = 8'(i_word >> i_shifts.red);
    assign green = 8'(i_word >> i_shifts.green);
    assign blue  = 8'(i_word >> i_shifts.blue);
    assign diff  = i_en && ({blue, green, red} != i_draw_rgb);

    always_comb begin
        o_res.diff = diff;
        o_res.r    = diff ? red   : 8'd0;
        o_res.g    = diff ? green : 8'd0;
        o_res.b    = diff ? blue  : 8'd0;
    end

endmodule

### hw/rtl/aapb_merge.sv
// Merging stage of the anti-aliased pixel blend core.
// Adds the channels of all differing neighbours and counts them.
// Depends on aapb_pkg.
module aapb_merge (
    input  aapb_pkg::t_lane_res [aapb_pkg::NUM_LANES-1:0] i_lanes,
    output aapb_pkg::t_sums                               o_sums
);
    import aapb_pkg::*;

    always_comb begin
        o_sums = '0;
        for (int k = 0; k < NUM_LANES; k++) begin
            o_sums.cnt   = o_sums.cnt + 4'(i_lanes[k].diff);
            o_sums.sum_r = o_sums.sum_r + 11'(i_lanes[k].r);
            o_sums.sum_g = o_sums.sum_g + 11'(i_lanes[k].g);
            o_sums.sum_b = o_sums.sum_b + 11'(i_lanes[k].b);
        end
    end

endmodule

### hw/rtl/aapb_blend.sv
// Channel blender of the anti-aliased pixel blend core.
// Moves one background channel toward the drawing channel by the brightness.
// Depends on aapb_pkg.
module aapb_blend (
    input  logic [7:0] i_fg,
    input  logic [7:0] i_bg,
    input  logic [8:0] i_bright,
    output logic [7:0] o_chan
);
    import aapb_pkg::*;

    logic        rising;
    logic [7:0]  delta;
    logic [16:0] prod;
    logic [16:0] prod_up;

    assign rising  = i_fg > i_bg;
    assign delta   = rising ? (i_fg - i_bg) : (i_bg - i_fg);
    assign prod    = 17'(delta) * 17'(i_bright);
    assign prod_up = prod + 17'd255;

    always_comb begin
        if (rising) begin
            o_chan = i_bg + prod[15:8];
        end else begin
            o_chan = i_bg - prod_up[15:8];
        end
    end

endmodule

### hw/rtl/antialias_pixel_blend_core.sv
// Top level of the anti-aliased pixel blend core.
// Instantiates eight aapb_lane, one aapb_merge and three aapb_blend; uses aapb_pkg.
//
// The core takes one pixel transaction per clock cycle unless o_in_stall is high. Its
// stages are neighbour decode in eight parallel lanes, channel summation, division
// of the sums by the neighbour count through a reciprocal multiply, the per-channel
// blend, and the repacking into the output register. Every stage is registered and
// each stage holds its transaction only while the stage after it is full, so a stall
// on the output side reaches the input after the five stages have filled up. The
// configuration registers may be written only while no transaction is in flight.
module antialias_pixel_blend_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [23:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [12:0] i_pos_x,
    input  logic [12:0] i_pos_y,
    input  logic [23:0] i_draw_rgb,
    input  logic [8:0]  i_brightness_q8,
    input  logic [7:0]  i_neighbor_use,
    input  logic [63:0] i_words_e_se,
    input  logic [63:0] i_words_s_sw,
    input  logic [63:0] i_words_w_nw,
    input  logic [63:0] i_words_n_ne,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [12:0] o_out_x,
    output logic [12:0] o_out_y,
    output logic [31:0] o_video_word
);
    import aapb_pkg::*;

    localparam int NUM_STAGES = 5;

    t_shifts     r_shifts;
    logic [13:0] r_frame_width;
    logic [13:0] r_frame_height;
    logic [23:0] r_background;

    logic [NUM_STAGES-1:0] r_vld;
    logic [NUM_STAGES-1:0] stage_en;

    logic                           east;
    logic                           south;
    logic                           west;
    logic                           north;
    logic [NUM_LANES-1:0]           in_frame;
    logic [NUM_LANES-1:0][31:0]     words;
    logic [8:0]                     bright_sat;
    t_lane_res [NUM_LANES-1:0]      n_lanes;

    t_lane_res [NUM_LANES-1:0] r_s1_lanes;
    logic [23:0]               r_s1_rgb;
    logic [8:0]                r_s1_bright;
    logic [12:0]               r_s1_x;
    logic [12:0]               r_s1_y;

    t_sums       n_s2_sums;
    t_sums       r_s2_sums;
    logic [23:0] r_s2_rgb;
    logic [8:0]  r_s2_bright;
    logic [12:0] r_s2_x;
    logic [12:0] r_s2_y;

    logic [16:0] recip;
    logic [27:0] quot_r;
    logic [27:0] quot_g;
    logic [27:0] quot_b;
    logic [23:0] n_s3_bg;
    logic [23:0] r_s3_bg;
    logic [23:0] r_s3_rgb;
    logic [8:0]  r_s3_bright;
    logic [12:0] r_s3_x;
    logic [12:0] r_s3_y;

    logic [23:0] n_s4_blend;
    logic [23:0] r_s4_blend;
    logic [12:0] r_s4_x;
    logic [12:0] r_s4_y;

    logic [31:0] n_video_word;
    logic [31:0] r_video_word;
    logic [12:0] r_out_x;
    logic [12:0] r_out_y;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shifts.red   <= 5'd16;
            r_shifts.green <= 5'd8;
            r_shifts.blue  <= 5'd0;
            r_frame_width  <= 14'd1024;
            r_frame_height <= 14'd768;
            r_background   <= 24'd0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_RED_SHIFT:    r_shifts.red   <= i_cfg_data[4:0];
                CFG_GREEN_SHIFT:  r_shifts.green <= i_cfg_data[4:0];
                CFG_BLUE_SHIFT:   r_shifts.blue  <= i_cfg_data[4:0];
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[13:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[13:0];
                CFG_BACKGROUND:   r_background   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // A stage may take a new transaction when it is empty or its contents move on.
    always_comb begin
        stage_en[NUM_STAGES-1] = !r_vld[NUM_STAGES-1] || !i_out_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    assign o_in_stall = !stage_en[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // Stage 1: neighbour lanes.
    assign east  = ({1'b0, i_pos_x} + 14'd1) < r_frame_width;
    assign south = ({1'b0, i_pos_y} + 14'd1) < r_frame_height;
    assign west  = i_pos_x != 13'd0;
    assign north = i_pos_y != 13'd0;

    assign in_frame = {east && north, north, west && north, west,
                       west && south, south, east && south, east};
    assign words    = {i_words_n_ne, i_words_w_nw, i_words_s_sw, i_words_e_se};

    assign bright_sat = (i_brightness_q8 > BRIGHT_FULL) ? BRIGHT_FULL : i_brightness_q8;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        aapb_lane u_lane (
            .i_word     (words[g]),
            .i_en       (i_neighbor_use[g] && in_frame[g]),
            .i_draw_rgb (i_draw_rgb),
            .i_shifts   (r_shifts),
            .o_res      (n_lanes[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[0]) begin
            r_s1_lanes  <= n_lanes;
            r_s1_rgb    <= i_draw_rgb;
            r_s1_bright <= bright_sat;
            r_s1_x      <= i_pos_x;
            r_s1_y      <= i_pos_y;
        end
    end

    // Stage 2: channel sums and neighbour count.
    aapb_merge u_merge (
        .i_lanes (r_s1_lanes),
        .o_sums  (n_s2_sums)
    );

    always_ff @(posedge i_clk) begin
        if (stage_en[1]) begin
            r_s2_sums   <= n_s2_sums;
            r_s2_rgb    <= r_s1_rgb;
            r_s2_bright <= r_s1_bright;
            r_s2_x      <= r_s1_x;
            r_s2_y      <= r_s1_y;
        end
    end

    // Stage 3: mean background by reciprocal multiply, or the fallback colour.
    assign recip  = f_recip(r_s2_sums.cnt);
    assign quot_r = 28'(r_s2_sums.sum_r) * 28'(recip);
    assign quot_g = 28'(r_s2_sums.sum_g) * 28'(recip);
    assign quot_b = 28'(r_s2_sums.sum_b) * 28'(recip);

    always_comb begin
        if (r_s2_sums.cnt == 4'd0) begin
            n_s3_bg = r_background;
        end else begin
            n_s3_bg = {quot_b[RECIP_FRAC+7:RECIP_FRAC], quot_g[RECIP_FRAC+7:RECIP_FRAC],
                       quot_r[RECIP_FRAC+7:RECIP_FRAC]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[2]) begin
            r_s3_bg     <= n_s3_bg;
            r_s3_rgb    <= r_s2_rgb;
            r_s3_bright <= r_s2_bright;
            r_s3_x      <= r_s2_x;
            r_s3_y      <= r_s2_y;
        end
    end

    // Stage 4: per-channel blend.
    for (genvar c = 0; c < 3; c++) begin : g_blend
        aapb_blend u_blend (
            .i_fg     (r_s3_rgb[8*c +: 8]),
            .i_bg     (r_s3_bg[8*c +: 8]),
            .i_bright (r_s3_bright),
            .o_chan   (n_s4_blend[8*c +: 8])
        );
    end

    always_ff @(posedge i_clk) begin
        if (stage_en[3]) begin
            r_s4_blend <= n_s4_blend;
            r_s4_x     <= r_s3_x;
            r_s4_y     <= r_s3_y;
        end
    end

    // Stage 5: repacking into the video word.
    assign n_video_word = ({24'd0, r_s4_blend[7:0]}   << r_shifts.red)
                        | ({24'd0, r_s4_blend[15:8]}  << r_shifts.green)
                        | ({24'd0, r_s4_blend[23:16]} << r_shifts.blue);

    always_ff @(posedge i_clk) begin
        if (stage_en[4]) begin
            r_video_word <= n_video_word;
            r_out_x      <= r_s4_x;
            r_out_y      <= r_s4_y;
        end
    end

    assign o_out_valid  = r_vld[NUM_STAGES-1];
    assign o_video_word = r_video_word;
    assign o_out_x      = r_out_x;
    assign o_out_y      = r_out_y;

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> ((&r_vld) && i_out_stall))
        else $error("input stalled while the pipeline has room");

    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[1] |-> (r_s2_sums.cnt <= 4'd8))
        else $error("neighbour count exceeds the number of lanes");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_vld[NUM_STAGES-2]))
        else $error("result appeared without a transaction in the blend stage");

    a_held_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[NUM_STAGES-1] && i_out_stall) |=> $stable(r_video_word))
        else $error("stalled video word changed");

endmodule

### verif/testbench.sv
// Self-checking testbench for antialias_pixel_blend_core, the anti-aliased pixel blend.
// A directed table and randomised pixels under several register settings are checked
// against pinned words or an in-bench predictor; depends on aapb_pkg and the core only.
module testbench;
    import aapb_pkg::*;

    localparam int DIR_ROWS    = 23;
    localparam int PHASES      = 7;
    localparam int PHASE_ITEMS = 100;
    localparam int CYCLE_LIMIT = 500000;

    typedef struct packed {
        logic [12:0]      x;
        logic [12:0]      y;
        logic [23:0]      rgb;
        logic [8:0]       bq;
        logic [7:0]       mask;
        logic [3:0][63:0] words;
    } t_pixel;

    typedef struct packed {
        t_pixel      px;
        logic        pin;
        logic [31:0] word;
    } t_row;

    typedef struct packed {
        logic [12:0] x;
        logic [12:0] y;
        logic [31:0] word;
    } t_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_idx = CFG_RED_SHIFT;
    logic [23:0] cfg_data = '0;
    logic        pix_valid = 1'b0;
    t_pixel      pix = '0;
    logic        pin_valid = 1'b0;
    logic [31:0] pin_word = '0;
    logic        out_stall = 1'b0;
    logic        in_stall;
    logic        out_valid;
    logic [12:0] out_x;
    logic [12:0] out_y;
    logic [31:0] video_word;

    logic [4:0]  sh_red = 5'd16;
    logic [4:0]  sh_green = 5'd8;
    logic [4:0]  sh_blue = 5'd0;
    logic [13:0] frame_w = 14'd1024;
    logic [13:0] frame_h = 14'd768;
    logic [23:0] bg_rgb = 24'd0;

    t_result     pending_px[$];
    t_row        directed_rows[DIR_ROWS];
    int          errors = 0;
    int          cycles = 0;
    int          stall_left = 0;
    bit          quiet = 1'b0;

    antialias_pixel_blend_core uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we),
        .i_cfg_idx(cfg_idx),
        .i_cfg_data(cfg_data),
        .i_in_valid(pix_valid),
        .o_in_stall(in_stall),
        .i_pos_x(pix.x),
        .i_pos_y(pix.y),
        .i_draw_rgb(pix.rgb),
        .i_brightness_q8(pix.bq),
        .i_neighbor_use(pix.mask),
        .i_words_e_se(pix.words[0]),
        .i_words_s_sw(pix.words[1]),
        .i_words_w_nw(pix.words[2]),
        .i_words_n_ne(pix.words[3]),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_x(out_x),
        .o_out_y(out_y),
        .o_video_word(video_word)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] chan_at(input logic [31:0] w, input logic [4:0] sh);
        return 8'(w >> sh);
    endfunction

    function automatic logic [31:0] pack_rgb(input logic [23:0] c);
        logic [63:0] word64;
        word64 = (64'(c[7:0]) << sh_red) | (64'(c[15:8]) << sh_green)
               | (64'(c[23:16]) << sh_blue);
        return word64[31:0];
    endfunction

    // Rising channels round the step down, falling channels round it up.
    function automatic logic [7:0] mix_chan(input logic [7:0] fg, input logic [7:0] bg,
                                            input int unsigned bright);
        int unsigned f;
        int unsigned g;
        f = fg;
        g = bg;
        if (f > g)
            return 8'(g + (((f - g) * bright) >> 8));
        return 8'(g - (((g - f) * bright + 255) >> 8));
    endfunction

    function automatic logic [31:0] blend_pixel(input t_pixel p);
        logic [31:0] nb[8];
        logic [7:0]  in_frame;
        logic [23:0] seen;
        logic [23:0] bg;
        int unsigned sr, sg, sb, cnt, bright;
        bit          east, south, west, north;
        int          i;
        east = (32'(p.x) + 1) < 32'(frame_w);
        south = (32'(p.y) + 1) < 32'(frame_h);
        west = p.x != 0;
        north = p.y != 0;
        in_frame = {east && north, north, west && north, west,
                    west && south, south, east && south, east};
        for (i = 0; i < 4; i++) begin
            nb[2 * i] = p.words[i][31:0];
            nb[2 * i + 1] = p.words[i][63:32];
        end
        bright = (p.bq > BRIGHT_FULL) ? 32'(BRIGHT_FULL) : 32'(p.bq);
        sr = 0;
        sg = 0;
        sb = 0;
        cnt = 0;
        for (i = 0; i < 8; i++) begin
            seen = (p.mask[i] && in_frame[i]) ?
                   {chan_at(nb[i], sh_blue), chan_at(nb[i], sh_green), chan_at(nb[i], sh_red)} :
                   p.rgb;
            if (seen != p.rgb) begin
                sr += seen[7:0];
                sg += seen[15:8];
                sb += seen[23:16];
                cnt++;
            end
        end
        if (cnt != 0)
            bg = {8'(sb / cnt), 8'(sg / cnt), 8'(sr / cnt)};
        else
            bg = bg_rgb;
        return pack_rgb({mix_chan(p.rgb[23:16], bg[23:16], bright),
                         mix_chan(p.rgb[15:8], bg[15:8], bright),
                         mix_chan(p.rgb[7:0], bg[7:0], bright)});
    endfunction

    function automatic t_row mk_row(input logic [12:0] x, input logic [12:0] y,
                                    input logic [23:0] rgb, input logic [8:0] bq,
                                    input logic [7:0] mask, input logic [63:0] e_se,
                                    input logic [63:0] s_sw, input logic [63:0] w_nw,
                                    input logic [63:0] n_ne, input logic pin,
                                    input logic [31:0] word);
        t_row r;
        r.px.x = x;
        r.px.y = y;
        r.px.rgb = rgb;
        r.px.bq = bq;
        r.px.mask = mask;
        r.px.words = {n_ne, w_nw, s_sw, e_se};
        r.pin = pin;
        r.word = word;
        return r;
    endfunction

    function automatic int unsigned idle_len();
        return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(12, 48);
    endfunction

    function automatic logic [12:0] pick_coord(input logic [13:0] extent);
        case ($urandom_range(0, 9))
            0: return 13'd0;
            1: return 13'(extent - 14'd1);
            2: return 13'(extent);
            3: return 13'h1fff;
            4, 5: return 13'($urandom_range(0, 8191));
            default: return 13'($urandom_range(0, (extent > 14'd8191) ? 8191 : extent));
        endcase
    endfunction

    function automatic t_pixel random_pixel();
        t_pixel      p;
        logic [23:0] shared;
        logic [31:0] w;
        int          i;
        p.x = pick_coord(frame_w);
        p.y = pick_coord(frame_h);
        p.rgb = 24'($urandom);
        case ($urandom_range(0, 9))
            0: p.bq = 9'd0;
            1: p.bq = BRIGHT_FULL;
            2: p.bq = 9'd255;
            3: p.bq = 9'd1;
            4: p.bq = 9'($urandom_range(257, 511));
            default: p.bq = 9'($urandom_range(0, 256));
        endcase
        case ($urandom_range(0, 7))
            0: p.mask = 8'h00;
            1, 2: p.mask = 8'hff;
            default: p.mask = 8'($urandom);
        endcase
        shared = 24'($urandom);
        for (i = 0; i < 8; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: w = $urandom;
                4, 5: w = pack_rgb(p.rgb);
                6, 7, 8: w = pack_rgb(shared);
                default: w = ($urandom_range(0, 1) != 0) ? 32'hffffffff : 32'h0;
            endcase
            if (i % 2 == 0)
                p.words[i / 2][31:0] = w;
            else
                p.words[i / 2][63:32] = w;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (errors < 100)
            $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycles, got,
                     want);
        errors++;
    endtask

    task automatic send_pixel(input t_row r);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 99) < 30) ? idle_len() : 0;
        if (gap != 0) begin
            pix_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        pix_valid <= 1'b1;
        pix <= r.px;
        pin_valid <= r.pin;
        pin_word <= r.word;
        do @(posedge i_clk); while (in_stall);
    endtask

    task automatic drain_pipeline();
        pix_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_px.size() != 0) @(posedge i_clk);
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [4:0] rs, input logic [4:0] gs,
                                input logic [4:0] bs, input logic [13:0] w,
                                input logic [13:0] h, input logic [23:0] bg);
        logic [23:0] vals[6];
        int          i;
        vals = '{24'(rs), 24'(gs), 24'(bs), 24'(w), 24'(h), bg};
        for (i = 0; i < 6; i++) begin
            cfg_we <= 1'b1;
            cfg_idx <= 3'(i);
            cfg_data <= vals[i];
            @(posedge i_clk);
        end
        cfg_we <= 1'b0;
        sh_red = rs;
        sh_green = gs;
        sh_blue = bs;
        frame_w = w;
        frame_h = h;
        bg_rgb = bg;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_stall <= 1'b1;
        end else if (!quiet && $urandom_range(0, 99) < 25) begin
            stall_left <= idle_len() - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin : check
        t_result want;
        if (i_rst_n && pix_valid && !in_stall) begin
            want.x = pix.x;
            want.y = pix.y;
            want.word = pin_valid ? pin_word : blend_pixel(pix);
            pending_px.push_back(want);
        end
        if (i_rst_n && out_valid && !out_stall) begin
            if (pending_px.size() == 0) begin
                report_mismatch("unexpected transaction", video_word, 32'h0);
            end else begin
                want = pending_px.pop_front();
                if (out_x !== want.x)
                    report_mismatch("out_x", 32'(out_x), 32'(want.x));
                if (out_y !== want.y)
                    report_mismatch("out_y", 32'(out_y), 32'(want.y));
                if (video_word !== want.word)
                    report_mismatch("video_word", video_word, want.word);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    initial begin
        int          k;
        int          phase;
        int          item;
        t_row        r;
        directed_rows[0] = mk_row(13'd0, 13'd0, 24'h000000, 9'd256, 8'h00, 64'h0, 64'h0,
                                  64'h0, 64'h0, 1'b1, 32'h00000000);
        directed_rows[1] = mk_row(13'd0, 13'd0, 24'hffffff, 9'd256, 8'h00, 64'h0, 64'h0,
                                  64'h0, 64'h0, 1'b1, 32'h00ffffff);
        directed_rows[2] = mk_row(13'd5, 13'd5, 24'hffffff, 9'd0, 8'hff, 64'h0, 64'h0,
                                  64'h0, 64'h0, 1'b1, 32'h00000000);
        directed_rows[3] = mk_row(13'd10, 13'd10, 24'h123456, 9'd511, 8'h00, 64'h0, 64'h0,
                                  64'h0, 64'h0, 1'b1, 32'h00563412);
        directed_rows[4] = mk_row(13'd10, 13'd10, 24'h123456, 9'd257, 8'h00, 64'h0, 64'h0,
                                  64'h0, 64'h0, 1'b1, 32'h00563412);
        directed_rows[5] = mk_row(13'h1fff, 13'h1fff, 24'h000000, 9'd128, 8'hff, '1, '1,
                                  '1, '1, 1'b0, 32'h0);
        directed_rows[6] = mk_row(13'h1fff, 13'h1fff, 24'h000000, 9'd256, 8'hff, '1, '1,
                                  '1, '1, 1'b1, 32'h00000000);
        directed_rows[7] = mk_row(13'd1023, 13'd767, 24'h4080c0, 9'd200, 8'hff,
                                  64'h01234567_89abcdef, 64'hfedcba98_76543210,
                                  64'h0f1e2d3c_4b5a6978, 64'h87a5c3e1_f0d2b496, 1'b0, 32'h0);
        directed_rows[8] = mk_row(13'd1022, 13'd766, 24'h4080c0, 9'd200, 8'hff,
                                  64'h01234567_89abcdef, 64'hfedcba98_76543210,
                                  64'h0f1e2d3c_4b5a6978, 64'h87a5c3e1_f0d2b496, 1'b0, 32'h0);
        for (k = 0; k < 8; k++)
            directed_rows[9 + k] = mk_row(13'd1, 13'd1, 24'h808080, 9'd100, 8'(1 << k),
                                          64'hdeadbeef_00112233, 64'h0f0f0f0f_f0f0f0f0,
                                          64'hffffffff_00000000, 64'h12345678_9abcdef0,
                                          1'b0, 32'h0);
        directed_rows[17] = mk_row(13'd5, 13'd5, 24'h332211, 9'd256, 8'hff,
                                   64'hab112233_00112233, 64'h00112233_ab112233,
                                   64'hab112233_ab112233, 64'h00112233_00112233,
                                   1'b1, 32'h00112233);
        directed_rows[18] = mk_row(13'd0, 13'd0, 24'h000000, 9'd1, 8'h01,
                                   64'hffffffff_00010101, '1, '1, '1, 1'b1, 32'h00000000);
        directed_rows[19] = mk_row(13'd0, 13'd0, 24'h000000, 9'd0, 8'h01,
                                   64'hffffffff_00010101, '1, '1, '1, 1'b1, 32'h00010101);
        directed_rows[20] = mk_row(13'd3, 13'd3, 24'hffffff, 9'd1, 8'h00, 64'h0, 64'h0,
                                   64'h0, 64'h0, 1'b1, 32'h00000000);
        directed_rows[21] = mk_row(13'd3, 13'd3, 24'hffffff, 9'd255, 8'h00, 64'h0, 64'h0,
                                   64'h0, 64'h0, 1'b1, 32'h00fefefe);
        directed_rows[22] = mk_row(13'h1fff, 13'd0, 24'haa55aa, 9'd77, 8'h5a,
                                   64'h13579bdf_2468ace0, 64'h00ff00ff_ff00ff00,
                                   64'hc0ffee00_badcafe0, 64'h55aa55aa_aa55aa55, 1'b0, 32'h0);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS; k++)
            send_pixel(directed_rows[k]);

        for (phase = 0; phase < PHASES; phase++) begin
            drain_pipeline();
            case (phase)
                0: write_config(5'd0, 5'd8, 5'd16, 14'd16, 14'd12, 24'($urandom));
                1: write_config(5'd24, 5'd31, 5'd25, 14'd0, 14'd0, 24'hffffff);
                2: write_config(5'd31, 5'd0, 5'd24, 14'd8192, 14'd8192, 24'h000000);
                3: write_config(5'd16, 5'd8, 5'd0, 14'h3fff, 14'd1, 24'($urandom));
                4: write_config(5'($urandom), 5'($urandom), 5'($urandom), 14'd1, 14'h3fff,
                                24'($urandom));
                5: write_config(5'($urandom), 5'($urandom), 5'($urandom),
                                14'($urandom_range(1, 64)), 14'($urandom_range(1, 64)),
                                24'($urandom));
                default: write_config(5'd16, 5'd8, 5'd0, 14'd1024, 14'd768, 24'h000000);
            endcase
            for (item = 0; item < PHASE_ITEMS; item++) begin
                if (item % 25 == 0)
                    quiet = ($urandom_range(0, 3) == 0);
                if (phase == 2 && item == 50)
                    drain_pipeline();
                r.px = random_pixel();
                r.pin = 1'b0;
                r.word = '0;
                send_pixel(r);
            end
        end

        quiet = 1'b0;
        drain_pipeline();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
